// ----- sv/ssvc_pkg.sv -----
// Shared types and constants for the sample slot store.
// Word structs, configuration register map and reset values; no dependencies.
`default_nettype none

package ssvc_pkg;

  localparam logic [1:0] ACT_STORE   = 2'd0;
  localparam logic [1:0] ACT_RAW     = 2'd1;
  localparam logic [1:0] ACT_CHECKED = 2'd2;

  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_SEND_INTERVAL       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INVALIDATE_INTERVAL = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LOWER_LIMIT         = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_UPPER_LIMIT         = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_INVALID_SUBSTITUTE  = 3'd4;

  localparam logic [31:0]        RST_SEND_INTERVAL       = 32'd600;
  localparam logic [31:0]        RST_INVALIDATE_INTERVAL = 32'd900;
  localparam logic signed [31:0] RST_LOWER_LIMIT         = 32'sh8000_0000;
  localparam logic signed [31:0] RST_UPPER_LIMIT         = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] RST_INVALID_SUBSTITUTE  = 32'sd65470464;

  typedef struct packed {
    logic [1:0]         action;
    logic [1:0]         slot;
    logic [31:0]        now;
    logic signed [31:0] sample;
  } in_word_t;

  typedef struct packed {
    logic               send_due;
    logic [1:0]         out_slot;
    logic signed [31:0] out_value;
    logic [31:0]        out_sample_time;
    logic [31:0]        previous_send_time;
    logic               last;
  } out_word_t;

  typedef struct packed {
    logic [31:0]        send_interval;
    logic [31:0]        invalidate_interval;
    logic signed [31:0] lower_limit;
    logic signed [31:0] upper_limit;
    logic signed [31:0] invalid_substitute;
  } cfg_t;

endpackage

`default_nettype wire

// ----- sv/ssvc_check.sv -----
// Validity check of one slot word for checked read-out.
// Depends on ssvc_pkg for the configuration struct.
`default_nettype none

module ssvc_check (
  input  var ssvc_pkg::cfg_t cfg,
  input  var logic               checked,
  input  var logic [31:0]        stale_edge,
  input  var logic signed [31:0] value,
  input  var logic [31:0]        sample_time,
  output var logic signed [31:0] value_chk
);
  import ssvc_pkg::*;

  logic bad;

  always_comb begin
    bad = (value < cfg.lower_limit) || (value > cfg.upper_limit) ||
          (stale_edge >= sample_time);
    value_chk = (checked && bad) ? cfg.invalid_substitute : value;
  end

endmodule

`default_nettype wire

// ----- sv/sample_slot_store_with_validity_check_unit.sv -----
// Sample slot store with send scheduling and raw or checked read-out.
// Store: result word registered at the accepting edge.
// Read-out: one result word per cycle while the output is not stalled, from the slot memory
// (one read port, registered read); the first word passes the read register, then the output
// register. Input is stalled until the final word is loaded. Reset loads configuration reset values
// and clears send state and per-slot valid bits at once. Depends on ssvc_pkg and ssvc_check.
`default_nettype none

module sample_slot_store_with_validity_check_unit #(
  parameter int SLOTS = 4
) (
  input  var logic                clk,
  input  var logic                rst_n,
  input  var logic                in_valid,
  output var logic                in_stall,
  input  var ssvc_pkg::in_word_t  in_word,
  output var logic                out_valid,
  input  var logic                out_stall,
  output var ssvc_pkg::out_word_t out_word,
  input  var logic                cfg_we,
  input  var logic [ssvc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  var logic [31:0]         cfg_wdata
);
  import ssvc_pkg::*;

  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  typedef enum logic {S_IDLE, S_EMIT} state_t;

  function automatic logic [31:0] sub_sat(input logic [31:0] a, input logic [31:0] b);
    sub_sat = (a >= b) ? (a - b) : 32'd0;
  endfunction

  state_t             state_r;
  logic [IW-1:0]      idx_r;
  logic               out_valid_r;
  out_word_t          out_word_r;
  logic               due_r;
  logic               first_r;
  logic [31:0]        last_send_r;
  logic [31:0]        prev_r;
  logic [31:0]        stale_r;
  logic               checked_r;
  cfg_t               cfg_r;
  logic [SLOTS-1:0]   vld_r;
  logic               rvld_r;
  logic [63:0]        rdata_r;
  logic [63:0]        mem [SLOTS];

  logic               accept;
  logic               out_free;
  logic               is_store;
  logic               is_read;
  logic               slot_ok;
  logic [IW-1:0]      wr_addr;
  logic               rd_en;
  logic [IW-1:0]      rd_addr;
  logic               idx_last;
  logic               due_nxt;
  logic               load_out;
  logic signed [31:0] rd_value;
  logic [31:0]        rd_time;
  logic signed [31:0] value_chk;

  always_comb begin
    in_stall = (state_r != S_IDLE) || (out_valid_r && out_stall);
    accept   = in_valid && !in_stall;
    out_free = !out_valid_r || !out_stall;
    is_store = in_word.action == ACT_STORE;
    is_read  = (in_word.action == ACT_RAW) || (in_word.action == ACT_CHECKED);
    slot_ok  = 32'(in_word.slot) < SLOTS;
    wr_addr  = IW'(in_word.slot);
    idx_last = idx_r == IW'(SLOTS - 1);
    rd_en    = (accept && is_read) ||
               ((state_r == S_EMIT) && out_free && !idx_last);
    rd_addr  = (state_r == S_IDLE) ? '0 : idx_r + IW'(1);
    due_nxt  = first_r || due_r ||
               (last_send_r <= sub_sat(in_word.now, cfg_r.send_interval));
    load_out = ((state_r == S_IDLE) && accept && is_store) ||
               ((state_r == S_EMIT) && out_free);
    rd_value = rvld_r ? rdata_r[63:32] : 32'sd0;
    rd_time  = rvld_r ? rdata_r[31:0] : 32'd0;
  end

  ssvc_check u_check (
    .cfg         (cfg_r),
    .checked     (checked_r),
    .stale_edge  (stale_r),
    .value       (rd_value),
    .sample_time (rd_time),
    .value_chk   (value_chk)
  );

  always_ff @(posedge clk) begin
    if (accept && is_store && slot_ok) begin
      mem[wr_addr] <= {in_word.sample, in_word.now};
    end
    if (rd_en) begin
      rdata_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r                   <= S_IDLE;
      idx_r                     <= '0;
      out_valid_r               <= 1'b0;
      due_r                     <= 1'b0;
      first_r                   <= 1'b1;
      last_send_r               <= 32'd0;
      vld_r                     <= '0;
      rvld_r                    <= 1'b0;
      checked_r                 <= 1'b0;
      cfg_r.send_interval       <= RST_SEND_INTERVAL;
      cfg_r.invalidate_interval <= RST_INVALIDATE_INTERVAL;
      cfg_r.lower_limit         <= RST_LOWER_LIMIT;
      cfg_r.upper_limit         <= RST_UPPER_LIMIT;
      cfg_r.invalid_substitute  <= RST_INVALID_SUBSTITUTE;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_SEND_INTERVAL:       cfg_r.send_interval       <= cfg_wdata;
          CFG_INVALIDATE_INTERVAL: cfg_r.invalidate_interval <= cfg_wdata;
          CFG_LOWER_LIMIT:         cfg_r.lower_limit         <= cfg_wdata;
          CFG_UPPER_LIMIT:         cfg_r.upper_limit         <= cfg_wdata;
          CFG_INVALID_SUBSTITUTE:  cfg_r.invalid_substitute  <= cfg_wdata;
          default: ;
        endcase
      end

      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end

      if (rd_en) begin
        rvld_r <= vld_r[rd_addr];
      end

      unique case (state_r)
        S_IDLE: begin
          if (accept && is_store) begin
            if (slot_ok) begin
              vld_r[wr_addr] <= 1'b1;
            end
            if (first_r) begin
              last_send_r <= in_word.now;
            end
            due_r       <= due_nxt;
            out_word_r  <= '{send_due: due_nxt, out_slot: 2'd0, out_value: 32'sd0,
                             out_sample_time: 32'd0, previous_send_time: 32'd0,
                             last: 1'b1};
          end else if (accept && is_read) begin
            due_r       <= 1'b0;
            first_r     <= 1'b0;
            prev_r      <= last_send_r;
            last_send_r <= in_word.now;
            stale_r     <= sub_sat(in_word.now, cfg_r.invalidate_interval);
            checked_r   <= in_word.action == ACT_CHECKED;
            idx_r       <= '0;
            state_r     <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            out_word_r  <= '{send_due: 1'b0, out_slot: 2'(idx_r), out_value: value_chk,
                             out_sample_time: rd_time, previous_send_time: prev_r,
                             last: idx_last};
            idx_r       <= idx_r + IW'(1);
            if (idx_last) begin
              state_r <= S_IDLE;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  a_emit_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_EMIT |-> in_stall)
    else $error("input taken during read-out");

  a_last_ends_readout: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_EMIT && out_free && idx_last |=> state_r == S_IDLE)
    else $error("read-out still active after final word");

  a_mid_word_in_readout: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_word_r.last |-> state_r == S_EMIT)
    else $error("non-final word outside read-out");

endmodule

`default_nettype wire
